FILE: src/stc_pkg.sv
// ============================================================================
// stc_pkg
// Shared types, opcodes and verb tables for the servo text command framer.
// ============================================================================
`default_nettype none

package stc_pkg;

    // Frame opcodes and fixed bytes.
    localparam logic [7:0] LEAD_BYTE       = 8'hAA;
    localparam logic [7:0] OP_SET_TARGET   = 8'h04;
    localparam logic [7:0] OP_SET_SPEED    = 8'h07;
    localparam logic [7:0] OP_SET_ACCEL    = 8'h09;
    localparam logic [7:0] OP_GET_POSITION = 8'h10;
    localparam logic [7:0] OP_GET_MOVING   = 8'h13;
    localparam logic [7:0] OP_GET_ERRORS   = 8'h21;
    localparam logic [7:0] OP_GO_HOME      = 8'h22;
    localparam logic [7:0] OP_STOP_SCRIPT  = 8'h24;
    localparam logic [7:0] OP_SUB          = 8'h27;
    localparam logic [7:0] OP_SUB_PARAM    = 8'h28;

    // Numeric limits.
    localparam logic [23:0] NUM_LIMIT = 24'd1000000;
    localparam logic [19:0] VAL14_MAX = 20'd16383;
    localparam logic [19:0] BYTE_MAX  = 20'd255;
    localparam logic [19:0] CHAN_MAX  = 20'd127;

    // Verb set.
    localparam int unsigned VERB_COUNT = 9;
    localparam logic [3:0]  VERB_DONE  = 4'd15;
    localparam logic [3:0]  VERB_LAST_POS = 4'd14;

    localparam logic [8:0] VC_SETTARGET   = 9'b000000001;
    localparam logic [8:0] VC_SETSPEED    = 9'b000000010;
    localparam logic [8:0] VC_SETACCEL    = 9'b000000100;
    localparam logic [8:0] VC_GOHOME      = 9'b000001000;
    localparam logic [8:0] VC_STOPSCRIPT  = 9'b000010000;
    localparam logic [8:0] VC_SUB         = 9'b000100000;
    localparam logic [8:0] VC_GETPOSITION = 9'b001000000;
    localparam logic [8:0] VC_GETMOVING   = 9'b010000000;
    localparam logic [8:0] VC_GETERRORS   = 9'b100000000;

    // Frame descriptor handed from the parser to the serializer.
    typedef struct packed {
        logic       rejected;
        logic [2:0] len;
        logic [7:0] dev;
        logic [7:0] op;
        logic [7:0] arg;
        logic [7:0] lo;
        logic [7:0] hi;
    } stc_frame_t;

    // Length of each verb.
    function automatic logic [3:0] verb_len(input logic [3:0] idx);
        logic [3:0] len;
        case (idx)
            4'd0:    len = 4'd9;
            4'd1:    len = 4'd8;
            4'd2:    len = 4'd8;
            4'd3:    len = 4'd6;
            4'd4:    len = 4'd10;
            4'd5:    len = 4'd3;
            4'd6:    len = 4'd11;
            4'd7:    len = 4'd14;
            4'd8:    len = 4'd9;
            default: len = 4'd0;
        endcase
        return len;
    endfunction

    // Verb text, right aligned, first character in the highest used byte.
    function automatic logic [111:0] verb_word(input logic [3:0] idx);
        logic [111:0] w;
        case (idx)
            4'd0:    w = 112'("settarget");
            4'd1:    w = 112'("setspeed");
            4'd2:    w = 112'("setaccel");
            4'd3:    w = 112'("gohome");
            4'd4:    w = 112'("stopscript");
            4'd5:    w = 112'("sub");
            4'd6:    w = 112'("getposition");
            4'd7:    w = 112'("getmovingstate");
            4'd8:    w = 112'("geterrors");
            default: w = '0;
        endcase
        return w;
    endfunction

    // True when verb idx has character c at position pos.
    function automatic logic verb_hit(input logic [3:0] idx, input logic [3:0] pos,
                                      input logic [7:0] c);
        logic [111:0] w;
        logic [3:0]   len;
        logic [3:0]   sh;
        logic [7:0]   ch;
        w   = verb_word(idx);
        len = verb_len(idx);
        sh  = len - pos - 4'd1;
        ch  = w[{sh, 3'b000} +: 8];
        return (pos < len) && (ch == c);
    endfunction

endpackage

`default_nettype wire

FILE: src/stc_cmd_if.sv
// ============================================================================
// stc_cmd_if
// Command character channel: one character or end mark per word.
// ============================================================================
`default_nettype none

interface stc_cmd_if;
    logic       valid;
    logic       ready;
    logic [7:0] char_code;
    logic       end_of_command;

    modport source (output valid, output char_code, output end_of_command, input ready);
    modport sink   (input valid, input char_code, input end_of_command, output ready);
endinterface

`default_nettype wire

FILE: src/stc_frame_if.sv
// ============================================================================
// stc_frame_if
// Frame byte channel: one frame byte or reject per word.
// ============================================================================
`default_nettype none

interface stc_frame_if;
    logic       valid;
    logic       ready;
    logic [7:0] frame_byte;
    logic       last_byte;
    logic       rejected;

    modport source (output valid, output frame_byte, output last_byte, output rejected,
                    input ready);
    modport sink   (input valid, input frame_byte, input last_byte, input rejected,
                    output ready);
endinterface

`default_nettype wire

FILE: src/stc_front.sv
// ============================================================================
// stc_front
// Character parser: tracks fields, numbers and verb match, and on the end
// mark builds a frame descriptor for the queue.
// ============================================================================
`default_nettype none

module stc_front (
    input  wire logic             clk,
    input  wire logic             rst_n,
    stc_cmd_if.sink               cmd,
    input  wire logic             q_full,
    output logic                  push,
    output stc_pkg::stc_frame_t   desc
);
    import stc_pkg::*;

    logic        at_start_reg,     at_start_next;
    logic [1:0]  field_number_reg, field_number_next;
    logic [1:0]  field_mode_reg,   field_mode_next;
    logic        comma_seen_reg,   comma_seen_next;
    logic [1:0]  legacy_phase_reg, legacy_phase_next;
    logic [3:0]  legacy_id_reg,    legacy_id_next;
    logic [7:0]  legacy_seq_reg,   legacy_seq_next;
    logic        legacy_bad_reg,   legacy_bad_next;
    logic [19:0] fv_reg [4];
    logic [19:0] fv_next [4];
    logic [3:0]  fnum_reg,         fnum_next;
    logic [8:0]  cand_reg,         cand_next;
    logic [3:0]  vpos_reg,         vpos_next;
    logic        nul_reg,          nul_next;

    logic        accept;
    logic [7:0]  c;
    logic [7:0]  c_low;
    logic        is_dig;
    logic [3:0]  dig;
    logic [8:0]  len_mask;
    logic [8:0]  hit_mask;
    logic [8:0]  cand_eff;
    logic [19:0] fv_cur;
    logic [23:0] fv_mul;
    logic [11:0] seq_mul;

    assign cmd.ready = !q_full;
    assign accept    = cmd.valid && cmd.ready;
    assign push      = accept && cmd.end_of_command;
    assign c         = cmd.char_code;
    assign is_dig    = (c >= 8'h30) && (c <= 8'h39);
    assign dig       = c[3:0];
    assign c_low     = ((c >= 8'h41) && (c <= 8'h5A)) ? (c + 8'd32) : c;
    assign fv_cur    = fv_reg[field_number_reg];
    assign fv_mul    = {1'b0, fv_cur, 3'b000} + {3'b000, fv_cur, 1'b0} + {20'd0, dig};
    assign seq_mul   = {1'b0, legacy_seq_reg, 3'b000} + {3'b000, legacy_seq_reg, 1'b0}
                     + {8'd0, dig};

    // Verb masks: lengths equal to the current position, and character hits.
    always_comb
    begin
        for (int i = 0; i < VERB_COUNT; i++)
        begin
            len_mask[i] = (verb_len(4'(i)) == vpos_reg);
            hit_mask[i] = verb_hit(4'(i), vpos_reg, c_low);
        end
    end

    // Per-character state update.
    always_comb
    begin
        at_start_next     = at_start_reg;
        field_number_next = field_number_reg;
        field_mode_next   = field_mode_reg;
        comma_seen_next   = comma_seen_reg;
        legacy_phase_next = legacy_phase_reg;
        legacy_id_next    = legacy_id_reg;
        legacy_seq_next   = legacy_seq_reg;
        legacy_bad_next   = legacy_bad_reg;
        fv_next           = fv_reg;
        fnum_next         = fnum_reg;
        cand_next         = cand_reg;
        vpos_next         = vpos_reg;
        nul_next          = nul_reg;
        if (accept)
        begin
            if (cmd.end_of_command)
            begin
                at_start_next     = 1'b1;
                field_number_next = 2'd0;
                field_mode_next   = 2'd0;
                comma_seen_next   = 1'b0;
                legacy_phase_next = 2'd0;
                legacy_id_next    = 4'd0;
                legacy_seq_next   = 8'd0;
                legacy_bad_next   = 1'b0;
                for (int i = 0; i < 4; i++)
                begin
                    fv_next[i] = 20'd0;
                end
                fnum_next         = 4'd0;
                cand_next         = '1;
                vpos_next         = 4'd0;
                nul_next          = 1'b0;
            end
            else if (!nul_reg)
            begin
                if (c == 8'h00)
                begin
                    nul_next = 1'b1;
                end
                else if (!(at_start_reg && (c == 8'h4D || c == 8'h6D)))
                begin
                    at_start_next = 1'b0;
                    // Legacy form tracking.
                    if (legacy_phase_reg == 2'd0)
                    begin
                        if (is_dig)
                        begin
                            legacy_id_next    = dig;
                            legacy_phase_next = 2'd1;
                        end
                        else
                        begin
                            legacy_bad_next   = 1'b1;
                            legacy_phase_next = 2'd2;
                        end
                    end
                    else if (legacy_phase_reg == 2'd1)
                    begin
                        if (is_dig)
                        begin
                            if (seq_mul > 12'(BYTE_MAX))
                            begin
                                legacy_bad_next   = 1'b1;
                                legacy_phase_next = 2'd2;
                            end
                            else
                            begin
                                legacy_seq_next = seq_mul[7:0];
                            end
                        end
                        else
                        begin
                            legacy_phase_next = 2'd2;
                        end
                    end
                    if (c == 8'h2C)
                    begin
                        // Comma closes the field.
                        comma_seen_next = 1'b1;
                        if (field_number_reg == 2'd1 && vpos_reg != VERB_DONE)
                        begin
                            cand_next = cand_reg & len_mask;
                            vpos_next = VERB_DONE;
                        end
                        if (field_number_reg != 2'd3)
                        begin
                            field_number_next = field_number_reg + 2'd1;
                            field_mode_next   = 2'd0;
                        end
                        else
                        begin
                            field_mode_next = 2'd2;
                        end
                    end
                    else
                    begin
                        // Verb matching on the second field.
                        if (field_number_reg == 2'd1 && vpos_reg != VERB_DONE
                            && cand_reg != 9'd0)
                        begin
                            if (c == 8'h20)
                            begin
                                cand_next = cand_reg & len_mask;
                                vpos_next = VERB_DONE;
                            end
                            else if (vpos_reg < VERB_LAST_POS)
                            begin
                                cand_next = cand_reg & hit_mask;
                                vpos_next = vpos_reg + 4'd1;
                            end
                            else
                            begin
                                cand_next = 9'd0;
                            end
                        end
                        // Number accumulation for the current field.
                        if (field_mode_reg == 2'd0)
                        begin
                            if (c != 8'h20)
                            begin
                                if (is_dig)
                                begin
                                    fv_next[field_number_reg]      = {16'd0, dig};
                                    fnum_next[field_number_reg]    = 1'b1;
                                    field_mode_next                = 2'd1;
                                end
                                else
                                begin
                                    field_mode_next = 2'd2;
                                end
                            end
                        end
                        else if (field_mode_reg == 2'd1)
                        begin
                            if (is_dig)
                            begin
                                if (fv_mul > NUM_LIMIT)
                                begin
                                    fnum_next[field_number_reg] = 1'b0;
                                    fv_next[field_number_reg]   = 20'd0;
                                    field_mode_next             = 2'd2;
                                end
                                else
                                begin
                                    fv_next[field_number_reg] = fv_mul[19:0];
                                end
                            end
                            else
                            begin
                                field_mode_next = 2'd2;
                            end
                        end
                    end
                end
                else
                begin
                    at_start_next = 1'b0;
                end
            end
        end
    end

    // Subroutine frame, with or without a parameter.
    function automatic stc_frame_t sub_frame(input logic [7:0] dev, input logic [19:0] n,
                                             input logic pnum, input logic [19:0] p);
        stc_frame_t f;
        f          = '0;
        f.rejected = 1'b1;
        f.len      = 3'd1;
        if (n <= BYTE_MAX)
        begin
            if (pnum)
            begin
                if (p <= VAL14_MAX)
                begin
                    f.rejected = 1'b0;
                    f.len      = 3'd6;
                    f.dev      = dev;
                    f.op       = OP_SUB_PARAM;
                    f.arg      = n[7:0];
                    f.lo       = {1'b0, p[6:0]};
                    f.hi       = {1'b0, p[13:7]};
                end
            end
            else
            begin
                f.rejected = 1'b0;
                f.len      = 3'd4;
                f.dev      = dev;
                f.op       = OP_SUB;
                f.arg      = n[7:0];
            end
        end
        return f;
    endfunction

    // A verb still open at the end mark is closed here.
    assign cand_eff = (field_number_reg == 2'd1 && vpos_reg != VERB_DONE) ?
                      (cand_reg & len_mask) : cand_reg;

    // Frame build from the state before the end mark.
    always_comb
    begin
        desc          = '0;
        desc.rejected = 1'b1;
        desc.len      = 3'd1;
        if (!comma_seen_reg)
        begin
            if (legacy_phase_reg != 2'd0 && !legacy_bad_reg)
            begin
                desc.rejected = 1'b0;
                desc.len      = 3'd4;
                desc.dev      = {4'd0, legacy_id_reg};
                desc.op       = OP_SUB;
                desc.arg      = legacy_seq_reg;
            end
        end
        else if (fnum_reg[0] && fv_reg[0] <= CHAN_MAX)
        begin
            if (fnum_reg[1])
            begin
                desc = sub_frame(fv_reg[0][7:0], fv_reg[1], fnum_reg[2], fv_reg[2]);
            end
            else
            begin
                unique case (cand_eff) inside
                    VC_SETTARGET, VC_SETSPEED, VC_SETACCEL:
                    begin
                        if (fnum_reg[2] && fnum_reg[3] && fv_reg[2] <= CHAN_MAX &&
                            ((cand_eff == VC_SETACCEL) ? (fv_reg[3] <= BYTE_MAX)
                                                       : (fv_reg[3] <= VAL14_MAX)))
                        begin
                            desc.rejected = 1'b0;
                            desc.len      = 3'd6;
                            desc.dev      = fv_reg[0][7:0];
                            desc.op       = (cand_eff == VC_SETTARGET) ? OP_SET_TARGET :
                                            (cand_eff == VC_SETSPEED)  ? OP_SET_SPEED  :
                                                                         OP_SET_ACCEL;
                            desc.arg      = fv_reg[2][7:0];
                            desc.lo       = {1'b0, fv_reg[3][6:0]};
                            desc.hi       = {1'b0, fv_reg[3][13:7]};
                        end
                    end
                    VC_GOHOME, VC_STOPSCRIPT, VC_GETMOVING, VC_GETERRORS:
                    begin
                        desc.rejected = 1'b0;
                        desc.len      = 3'd3;
                        desc.dev      = fv_reg[0][7:0];
                        desc.op       = (cand_eff == VC_GOHOME)     ? OP_GO_HOME     :
                                        (cand_eff == VC_STOPSCRIPT) ? OP_STOP_SCRIPT :
                                        (cand_eff == VC_GETMOVING)  ? OP_GET_MOVING  :
                                                                      OP_GET_ERRORS;
                    end
                    VC_SUB:
                    begin
                        if (fnum_reg[2])
                        begin
                            desc = sub_frame(fv_reg[0][7:0], fv_reg[2], fnum_reg[3],
                                             fv_reg[3]);
                        end
                    end
                    VC_GETPOSITION:
                    begin
                        if (fnum_reg[2] && fv_reg[2] <= CHAN_MAX)
                        begin
                            desc.rejected = 1'b0;
                            desc.len      = 3'd4;
                            desc.dev      = fv_reg[0][7:0];
                            desc.op       = OP_GET_POSITION;
                            desc.arg      = fv_reg[2][7:0];
                        end
                    end
                    default:
                    begin
                        desc.rejected = 1'b1;
                    end
                endcase
            end
        end
    end

    // State registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            at_start_reg     <= 1'b1;
            field_number_reg <= 2'd0;
            field_mode_reg   <= 2'd0;
            comma_seen_reg   <= 1'b0;
            legacy_phase_reg <= 2'd0;
            legacy_id_reg    <= 4'd0;
            legacy_seq_reg   <= 8'd0;
            legacy_bad_reg   <= 1'b0;
            for (int i = 0; i < 4; i++)
            begin
                fv_reg[i] <= 20'd0;
            end
            fnum_reg         <= 4'd0;
            cand_reg         <= '1;
            vpos_reg         <= 4'd0;
            nul_reg          <= 1'b0;
        end
        else
        begin
            at_start_reg     <= at_start_next;
            field_number_reg <= field_number_next;
            field_mode_reg   <= field_mode_next;
            comma_seen_reg   <= comma_seen_next;
            legacy_phase_reg <= legacy_phase_next;
            legacy_id_reg    <= legacy_id_next;
            legacy_seq_reg   <= legacy_seq_next;
            legacy_bad_reg   <= legacy_bad_next;
            fv_reg           <= fv_next;
            fnum_reg         <= fnum_next;
            cand_reg         <= cand_next;
            vpos_reg         <= vpos_next;
            nul_reg          <= nul_next;
        end
    end

endmodule

`default_nettype wire

FILE: src/stc_queue.sv
// ============================================================================
// stc_queue
// Two-entry queue of frame descriptors between parser and serializer.
// ============================================================================
`default_nettype none

module stc_queue (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             push,
    input  stc_pkg::stc_frame_t   push_desc,
    input  wire logic             pop,
    output stc_pkg::stc_frame_t   head,
    output logic                  empty,
    output logic                  full,
    output logic [1:0]            count
);
    import stc_pkg::*;

    stc_frame_t  mem_reg [2];
    logic        wr_ptr_reg, wr_ptr_next;
    logic        rd_ptr_reg, rd_ptr_next;
    logic [1:0]  count_reg,  count_next;

    assign head  = mem_reg[rd_ptr_reg];
    assign empty = (count_reg == 2'd0);
    assign full  = (count_reg == 2'd2);
    assign count = count_reg;

    // Pointer and occupancy update.
    always_comb
    begin
        wr_ptr_next = push ? !wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop  ? !rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Entry storage.
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_desc;
        end
    end

endmodule

`default_nettype wire

FILE: src/stc_back.sv
// ============================================================================
// stc_back
// Serializer: sends the head descriptor out one byte per word through an
// output register.
// ============================================================================
`default_nettype none

module stc_back (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  stc_pkg::stc_frame_t   head,
    input  wire logic             empty,
    output logic                  pop,
    stc_frame_if.source           frame
);
    import stc_pkg::*;

    logic [2:0] idx_reg,   idx_next;
    logic       valid_reg, valid_next;
    logic [7:0] byte_reg;
    logic       last_reg;
    logic       rej_reg;
    logic       load;
    logic       is_last;
    logic [7:0] sel;

    assign load    = !empty && (!valid_reg || frame.ready);
    assign is_last = (idx_reg == head.len - 3'd1);
    assign pop     = load && is_last;

    // Byte select within the frame.
    always_comb
    begin
        case (idx_reg)
            3'd0:    sel = head.rejected ? 8'h00 : LEAD_BYTE;
            3'd1:    sel = head.dev;
            3'd2:    sel = head.op;
            3'd3:    sel = head.arg;
            3'd4:    sel = head.lo;
            3'd5:    sel = head.hi;
            default: sel = 8'h00;
        endcase
    end

    always_comb
    begin
        idx_next   = load ? (is_last ? 3'd0 : idx_reg + 3'd1) : idx_reg;
        valid_next = load ? 1'b1 : (frame.ready ? 1'b0 : valid_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg   <= 3'd0;
            valid_reg <= 1'b0;
        end
        else
        begin
            idx_reg   <= idx_next;
            valid_reg <= valid_next;
        end
    end

    // Output payload register.
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            byte_reg <= sel;
            last_reg <= is_last;
            rej_reg  <= head.rejected;
        end
    end

    assign frame.valid      = valid_reg;
    assign frame.frame_byte = byte_reg;
    assign frame.last_byte  = last_reg;
    assign frame.rejected   = rej_reg;

endmodule

`default_nettype wire

FILE: src/servo_text_command_to_frame_core.sv
// ============================================================================
// servo_text_command_to_frame_core
// Turns a text servo command into a serial controller frame or a reject.
// ============================================================================
// Usage:
//   cmd carries one character per word; a word with end_of_command set closes
//   the command and its character is ignored. frame carries the result: the
//   3, 4 or 6 bytes of a frame with last_byte on the final one, or a single
//   word with rejected and last_byte set and a zero byte.
//   Characters are taken one per cycle while the queue is not full. On the end
//   mark the parser builds a frame descriptor in the same cycle and pushes it
//   into a two-entry queue; the first byte then passes from the queue head
//   through the output register onto frame. The serializer sends one byte per
//   cycle while the receiver takes them, and pops the queue head with the last
//   byte of a frame; cmd.ready drops only while both queue entries are in use.
//   Reset empties the queue and the output register and clears the parser.
//   When the receiver stalls, the output word holds and the queue fills.
// ============================================================================
`default_nettype none

module servo_text_command_to_frame_core (
    input  wire logic   clk,
    input  wire logic   rst_n,
    stc_cmd_if.sink     cmd,
    stc_frame_if.source frame
);
    import stc_pkg::*;

    stc_frame_t push_desc;
    stc_frame_t head;
    logic       push;
    logic       pop;
    logic       empty;
    logic       full;
    logic [1:0] count;

    stc_front u_front (
        .clk    (clk),
        .rst_n  (rst_n),
        .cmd    (cmd),
        .q_full (full),
        .push   (push),
        .desc   (push_desc)
    );

    stc_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_desc (push_desc),
        .pop       (pop),
        .head      (head),
        .empty     (empty),
        .full      (full),
        .count     (count)
    );

    stc_back u_back (
        .clk   (clk),
        .rst_n (rst_n),
        .head  (head),
        .empty (empty),
        .pop   (pop),
        .frame (frame)
    );

    // The queue never holds more than two descriptors.
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count != 2'd3)
        else $error("frame queue overflow");

    // A pushed descriptor is present on the next cycle.
    a_push_lands: assert property (@(posedge clk) disable iff (!rst_n)
        push |=> count != 2'd0)
        else $error("pushed frame lost");

    // A reject is always a single final word.
    a_reject_last: assert property (@(posedge clk) disable iff (!rst_n)
        (frame.valid && frame.rejected) |-> (frame.last_byte && frame.frame_byte == 8'h00))
        else $error("reject word malformed");

endmodule

`default_nettype wire
